// ===== hdl/tc8_pkg.sv =====
package tc8_pkg;

	// operation codes
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;

	// register selects
	localparam logic [2:0] SEL_CONTROL = 3'd0;
	localparam logic [2:0] SEL_COUNT   = 3'd1;
	localparam logic [2:0] SEL_COMPARE = 3'd2;
	localparam logic [2:0] SEL_ENABLE  = 3'd3;
	localparam logic [2:0] SEL_FLAGS   = 3'd4;

	// clock select codes
	localparam logic [2:0] CS_STOP    = 3'd0;
	localparam logic [2:0] CS_DIV1    = 3'd1;
	localparam logic [2:0] CS_DIV8    = 3'd2;
	localparam logic [2:0] CS_DIV64   = 3'd3;
	localparam logic [2:0] CS_DIV256  = 3'd4;
	localparam logic [2:0] CS_DIV1024 = 3'd5;

	// waveform modes, {ctrl[3], ctrl[6]}
	localparam logic [1:0] WAVE_NORMAL = 2'd0;
	localparam logic [1:0] WAVE_PHASE  = 2'd1;
	localparam logic [1:0] WAVE_CTC    = 2'd2;
	localparam logic [1:0] WAVE_FAST   = 2'd3;

	// compare output modes
	localparam logic [1:0] COM_OFF    = 2'd0;
	localparam logic [1:0] COM_TOGGLE = 2'd1;
	localparam logic [1:0] COM_CLEAR  = 2'd2;
	localparam logic [1:0] COM_SET    = 2'd3;

	// bits of the control byte that are not clock select
	localparam logic [7:0] CLOCK_SELECT_KEEP = 8'hF8;

	typedef struct packed {
		logic [1:0] operation;
		logic [2:0] register_select;
		logic [7:0] write_data;
	} tc8_item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       overflow_flag;
		logic       compare_flag;
		logic       pwm_pin;
		logic       overflow_irq;
		logic       compare_irq;
	} tc8_result_t;

	// phase-correct folds into normal
	function automatic logic [1:0] wave_mode(input logic [6:0] ctrl);
		logic [1:0] m;
		m = {ctrl[3], ctrl[6]};
		return (m == WAVE_PHASE) ? WAVE_NORMAL : m;
	endfunction

endpackage

// ===== hdl/timer_counter_8bit_pwm_top.sv =====
// channel  direction  handshake             payload
// in       input      in_valid / in_ready   operation, register_select, write_data
// out      output     out_valid / out_ready read_data, overflow_flag, compare_flag,
//                                           pwm_pin, overflow_irq, compare_irq
//
// one transaction per cycle sustained unless out stalls; each input transaction
// yields one result, via the input register, then timer state and result register
// the timer state updates in the same cycle the result register loads
// arst_n clears the pipeline valids and all timer state (timer stopped)
// a stall on out holds both stages; in_ready drops only when both stages are full
module timer_counter_8bit_pwm_top import tc8_pkg::*; #(
	parameter int COUNTER_WIDTH  = 8,
	parameter int PRESCALE_WIDTH = 10
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] operation,
	input  logic [2:0] register_select,
	input  logic [7:0] write_data,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_data,
	output logic       overflow_flag,
	output logic       compare_flag,
	output logic       pwm_pin,
	output logic       overflow_irq,
	output logic       compare_irq
);

	logic        valid_s1;
	tc8_item_t   item_s1;
	logic        valid_s2;
	tc8_result_t result_s2;

	logic        advance;
	logic        step;
	logic        tick;
	logic        timer_due;
	logic [2:0]  clk_sel;
	tc8_result_t result_next;

	// result register frees up when empty or being taken this cycle
	assign advance  = !valid_s2 || out_ready;
	// item in the input register is processed as it moves to the result register
	assign step     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;
	assign tick     = step && (item_s1.operation == OP_TICK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.operation       <= operation;
			item_s1.register_select <= register_select;
			item_s1.write_data      <= write_data;
		end
	end

	tc8_prescaler #(
		.PRESCALE_WIDTH(PRESCALE_WIDTH)
	) u_prescaler (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick    (tick),
		.clk_sel (clk_sel),
		.due     (timer_due)
	);

	tc8_core #(
		.COUNTER_WIDTH(COUNTER_WIDTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.item      (item_s1),
		.timer_due (timer_due),
		.clk_sel   (clk_sel),
		.result    (result_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_s2 <= result_next;
		end
	end

	assign out_valid     = valid_s2;
	assign read_data     = result_s2.read_data;
	assign overflow_flag = result_s2.overflow_flag;
	assign compare_flag  = result_s2.compare_flag;
	assign pwm_pin       = result_s2.pwm_pin;
	assign overflow_irq  = result_s2.overflow_irq;
	assign compare_irq   = result_s2.compare_irq;

endmodule

// ===== hdl/tc8_prescaler.sv =====
module tc8_prescaler import tc8_pkg::*; #(
	parameter int PRESCALE_WIDTH = 10
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       tick,
	input  logic [2:0] clk_sel,
	output logic       due
);

	logic [PRESCALE_WIDTH-1:0] count_q;
	logic [PRESCALE_WIDTH-1:0] count_next;
	logic                      hit;

	assign count_next = count_q + PRESCALE_WIDTH'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (tick) begin
			count_q <= count_next;
		end
	end

	// divided clock fires when the low bits of the new count are all zero
	always_comb begin
		case (clk_sel)
			CS_DIV1:    hit = 1'b1;
			CS_DIV8:    hit = (count_next[2:0] == '0);
			CS_DIV64:   hit = (count_next[5:0] == '0);
			CS_DIV256:  hit = (count_next[7:0] == '0);
			CS_DIV1024: hit = (count_next[9:0] == '0);
			default:    hit = 1'b0;
		endcase
	end

	assign due = tick && hit;

endmodule

// ===== hdl/tc8_core.sv =====
module tc8_core import tc8_pkg::*; #(
	parameter int COUNTER_WIDTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  tc8_item_t   item,
	input  logic        timer_due,
	output logic [2:0]  clk_sel,
	output tc8_result_t result
);

	logic [6:0]               ctrl_q, ctrl_d;
	logic [COUNTER_WIDTH-1:0] cnt_q, cnt_d;
	logic [COUNTER_WIDTH-1:0] cmp_q, cmp_d;
	logic [COUNTER_WIDTH-1:0] buf_q, buf_d;
	logic [1:0]               ena_q, ena_d;
	logic [1:0]               flg_q, flg_d;
	logic                     pin_q, pin_d;

	logic [7:0]               cs_full;
	logic [1:0]               mode_cur;
	logic [1:0]               com_cur;
	logic [1:0]               mode_new;
	logic [1:0]               com_new;
	logic                     match;
	logic                     at_max;
	logic [COUNTER_WIDTH-1:0] wdata_ext;
	logic [7:0]               rd;
	logic                     connected;

	assign cs_full   = {1'b0, ctrl_q} & ~CLOCK_SELECT_KEEP;
	assign clk_sel   = cs_full[2:0];
	assign mode_cur  = wave_mode(ctrl_q);
	assign com_cur   = ctrl_q[5:4];
	assign match     = (cnt_q == cmp_q);
	assign at_max    = (cnt_q == '1);
	assign wdata_ext = COUNTER_WIDTH'(item.write_data);

	always_comb begin
		ctrl_d = ctrl_q;
		cnt_d  = cnt_q;
		cmp_d  = cmp_q;
		buf_d  = buf_q;
		ena_d  = ena_q;
		flg_d  = flg_q;
		pin_d  = pin_q;
		rd     = '0;

		if (item.operation == OP_TICK) begin
			if (timer_due) begin
				if (match) begin
					flg_d[1] = 1'b1;
					case (com_cur)
						COM_TOGGLE: pin_d = (mode_cur == WAVE_FAST) ? pin_q : ~pin_q;
						COM_CLEAR:  pin_d = 1'b0;
						COM_SET:    pin_d = 1'b1;
						default:    pin_d = pin_q;
					endcase
				end
				if (mode_cur == WAVE_CTC && match) begin
					cnt_d = '0;
				end else begin
					cnt_d = cnt_q + COUNTER_WIDTH'(1);
				end
				if (at_max) begin
					flg_d[0] = 1'b1;
					if (mode_cur == WAVE_FAST) begin
						cmp_d = buf_q;
						if (com_cur == COM_CLEAR) begin
							pin_d = 1'b1;
						end else if (com_cur == COM_SET) begin
							pin_d = 1'b0;
						end
					end
				end
			end
		end else if (item.operation == OP_READ) begin
			case (item.register_select)
				SEL_CONTROL: rd = {1'b0, ctrl_q};
				SEL_COUNT:   rd = cnt_q[7:0];
				SEL_COMPARE: rd = (mode_cur == WAVE_FAST) ? buf_q[7:0] : cmp_q[7:0];
				SEL_ENABLE:  rd = {6'd0, ena_q};
				SEL_FLAGS:   rd = {6'd0, flg_q};
				default:     rd = '0;
			endcase
		end else if (item.operation == OP_WRITE) begin
			case (item.register_select)
				SEL_CONTROL: ctrl_d = item.write_data[6:0];
				SEL_COUNT:   cnt_d  = wdata_ext;
				SEL_COMPARE: begin
					buf_d = wdata_ext;
					if (mode_cur != WAVE_FAST) begin
						cmp_d = wdata_ext;
					end
				end
				SEL_ENABLE:  ena_d = item.write_data[1:0];
				SEL_FLAGS:   flg_d = flg_q & ~item.write_data[1:0];
				default:     ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0;
			cnt_q  <= '0;
			cmp_q  <= '0;
			buf_q  <= '0;
			ena_q  <= '0;
			flg_q  <= '0;
			pin_q  <= 1'b0;
		end else if (step) begin
			ctrl_q <= ctrl_d;
			cnt_q  <= cnt_d;
			cmp_q  <= cmp_d;
			buf_q  <= buf_d;
			ena_q  <= ena_d;
			flg_q  <= flg_d;
			pin_q  <= pin_d;
		end
	end

	// pin shows only while the compare output is hooked up
	assign mode_new  = wave_mode(ctrl_d);
	assign com_new   = ctrl_d[5:4];
	assign connected = (com_new != COM_OFF) &&
		!(mode_new == WAVE_FAST && com_new == COM_TOGGLE);

	assign result.read_data     = rd;
	assign result.overflow_flag = flg_d[0];
	assign result.compare_flag  = flg_d[1];
	assign result.pwm_pin       = connected && pin_d;
	assign result.overflow_irq  = flg_d[0] && ena_d[0];
	assign result.compare_irq   = flg_d[1] && ena_d[1];

endmodule

// ===== hdl/tc8_checker.sv =====
module tc8_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] read_data,
	input logic       overflow_flag,
	input logic       compare_flag,
	input logic       pwm_pin,
	input logic       overflow_irq,
	input logic       compare_irq
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_data) &&
			$stable(overflow_flag) && $stable(compare_flag) && $stable(pwm_pin))
		else $error("stalled result changed");

	// interrupt lines only with their flag set
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow_irq |-> overflow_flag)
		else $error("overflow irq without flag");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && compare_irq |-> compare_flag)
		else $error("compare irq without flag");

	// nothing comes out right after reset
	assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("result valid out of reset");

endmodule

bind timer_counter_8bit_pwm_top tc8_checker u_tc8_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.read_data     (read_data),
	.overflow_flag (overflow_flag),
	.compare_flag  (compare_flag),
	.pwm_pin       (pwm_pin),
	.overflow_irq  (overflow_irq),
	.compare_irq   (compare_irq)
);

// ===== tb/sv/tb_timer_counter_8bit_pwm_top.sv =====
module tb_timer_counter_8bit_pwm_top;
	import tc8_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// status and enable bit positions
	localparam int OVF_BIT = 0;
	localparam int OCF_BIT = 1;

	localparam logic [7:0] COUNT_TOP = 8'hFF;
	localparam int RANDOM_ITEMS = 1950;
	localparam int MAX_REPORTS = 10;

	// clock, reset and dut input ports, all known from time zero
	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] operation = OP_TICK;
	logic [2:0] register_select = SEL_CONTROL;
	logic [7:0] write_data = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] read_data;
	logic       overflow_flag;
	logic       compare_flag;
	logic       pwm_pin;
	logic       overflow_irq;
	logic       compare_irq;

	// predicted timer state, mirrors the peripheral registers
	logic [6:0] tm_ctrl;
	logic [7:0] tm_count;
	logic [7:0] tm_ocr;
	logic [7:0] tm_ocr_buf;
	logic [9:0] tm_prescale;
	logic [1:0] tm_enables;
	logic [1:0] tm_flags;
	logic       tm_pin;

	// stimulus and scoreboard storage
	tc8_item_t   bus_items_pending[$];
	tc8_result_t status_words_due[$];
	tc8_item_t   offered;

	int total_items = 0;
	int accepted_count = 0;
	int results_checked = 0;
	int error_count = 0;
	int wraps_seen = 0;
	int matches_seen = 0;
	int send_wait = 0;
	int recv_wait = 0;
	logic quiet_stretch = 1'b0;
	logic hold_off = 1'b0;

	timer_counter_8bit_pwm_top u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.operation      (operation),
		.register_select(register_select),
		.write_data     (write_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.read_data      (read_data),
		.overflow_flag  (overflow_flag),
		.compare_flag   (compare_flag),
		.pwm_pin        (pwm_pin),
		.overflow_irq   (overflow_irq),
		.compare_irq    (compare_irq)
	);

	always #1 clk = ~clk;

	// waveform bits 6 and 3 both set select fast pwm
	function automatic logic is_fast_pwm();
		return tm_ctrl[3] && tm_ctrl[6];
	endfunction

	// per-transaction idle draw, zero throughout a quiet stretch
	function automatic int draw_idle();
		return quiet_stretch ? 0 : int'($urandom_range(0, 7));
	endfunction

	// corner-heavy byte for compare and count writes
	function automatic logic [7:0] pick_byte();
		int roll;
		roll = $urandom_range(0, 5);
		if (roll == 0)
			return 8'h00;
		else if (roll == 1)
			return COUNT_TOP;
		else
			return 8'($urandom_range(0, 255));
	endfunction

	// applies one bus transaction to the predicted timer, returns the status word
	function automatic tc8_result_t apply_bus_item(input tc8_item_t it);
		tc8_result_t r;
		logic [1:0] com;
		logic [7:0] old;
		logic       tick_due;
		logic       fast;
		r = '0;
		case (it.operation)
			OP_TICK: begin
				// prescaler runs free on every tick, whatever the clock select
				tm_prescale = tm_prescale + 10'd1;
				case (tm_ctrl[2:0])
					CS_DIV1:    tick_due = 1'b1;
					CS_DIV8:    tick_due = (tm_prescale[2:0] == '0);
					CS_DIV64:   tick_due = (tm_prescale[5:0] == '0);
					CS_DIV256:  tick_due = (tm_prescale[7:0] == '0);
					CS_DIV1024: tick_due = (tm_prescale == '0);
					default:    tick_due = 1'b0;
				endcase
				if (tick_due) begin
					fast = is_fast_pwm();
					com = tm_ctrl[5:4];
					old = tm_count;
					if (old == tm_ocr) begin
						matches_seen++;
						tm_flags[OCF_BIT] = 1'b1;
						if (com == COM_CLEAR)
							tm_pin = 1'b0;
						else if (com == COM_SET)
							tm_pin = 1'b1;
						else if (com == COM_TOGGLE && !fast)
							tm_pin = ~tm_pin;
					end
					// ctc restarts on match, other modes count up and wrap
					if ({tm_ctrl[3], tm_ctrl[6]} == WAVE_CTC && old == tm_ocr)
						tm_count = 8'h00;
					else
						tm_count = old + 8'd1;
					if (old == COUNT_TOP) begin
						wraps_seen++;
						tm_flags[OVF_BIT] = 1'b1;
						// fast pwm reloads the compare value at top and restarts the pulse
						if (fast) begin
							tm_ocr = tm_ocr_buf;
							if (com == COM_CLEAR)
								tm_pin = 1'b1;
							else if (com == COM_SET)
								tm_pin = 1'b0;
						end
					end
				end
			end
			OP_READ: begin
				case (it.register_select)
					SEL_CONTROL: r.read_data = {1'b0, tm_ctrl};
					SEL_COUNT:   r.read_data = tm_count;
					SEL_COMPARE: r.read_data = is_fast_pwm() ? tm_ocr_buf : tm_ocr;
					SEL_ENABLE:  r.read_data = {6'd0, tm_enables};
					SEL_FLAGS:   r.read_data = {6'd0, tm_flags};
					default:     r.read_data = 8'h00;
				endcase
			end
			OP_WRITE: begin
				case (it.register_select)
					SEL_CONTROL: tm_ctrl = it.write_data[6:0];
					SEL_COUNT:   tm_count = it.write_data;
					SEL_COMPARE: begin
						// double buffered only in fast pwm
						tm_ocr_buf = it.write_data;
						if (!is_fast_pwm())
							tm_ocr = it.write_data;
					end
					SEL_ENABLE:  tm_enables = it.write_data[1:0];
					SEL_FLAGS:   tm_flags = tm_flags & ~it.write_data[1:0];
					default: ;
				endcase
			end
			default: ;
		endcase
		com = tm_ctrl[5:4];
		r.overflow_flag = tm_flags[OVF_BIT];
		r.compare_flag = tm_flags[OCF_BIT];
		// pin is disconnected for com off, and for toggle in fast pwm
		r.pwm_pin = (com != COM_OFF && !(is_fast_pwm() && com == COM_TOGGLE)) ? tm_pin : 1'b0;
		r.overflow_irq = tm_flags[OVF_BIT] & tm_enables[OVF_BIT];
		r.compare_irq = tm_flags[OCF_BIT] & tm_enables[OCF_BIT];
		return r;
	endfunction

	task automatic queue_item(input logic [1:0] op, input logic [2:0] sel,
			input logic [7:0] data);
		tc8_item_t it;
		it.operation = op;
		it.register_select = sel;
		it.write_data = data;
		bus_items_pending.push_back(it);
		total_items++;
	endtask

	// driver: offers queued transactions, predicts each one as it is accepted
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				status_words_due.push_back(apply_bus_item(offered));
				accepted_count++;
				// now and then switch between idling and back-to-back stretches
				if (accepted_count % 160 == 0)
					quiet_stretch <= ($urandom_range(0, 2) == 0);
			end
			if (!in_valid || in_ready) begin
				if (send_wait == 0 && bus_items_pending.size() != 0) begin
					offered = bus_items_pending.pop_front();
					operation <= offered.operation;
					register_select <= offered.register_select;
					write_data <= offered.write_data;
					in_valid <= 1'b1;
					send_wait = draw_idle();
				end else begin
					in_valid <= 1'b0;
					if (send_wait != 0)
						send_wait--;
				end
			end
		end
	end

	// monitor: checks each accepted status word against the oldest prediction
	always @(posedge clk) begin
		tc8_result_t got;
		tc8_result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				got.read_data = read_data;
				got.overflow_flag = overflow_flag;
				got.compare_flag = compare_flag;
				got.pwm_pin = pwm_pin;
				got.overflow_irq = overflow_irq;
				got.compare_irq = compare_irq;
				if (status_words_due.size() == 0) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$display("unexpected transaction at %0t: rd=%02h", $realtime, got.read_data);
				end else begin
					want = status_words_due.pop_front();
					if (got !== want) begin
						error_count++;
						if (error_count <= MAX_REPORTS)
							$display("mismatch on result %0d: expected rd=%02h ovf=%b ocf=%b pin=%b oirq=%b cirq=%b, got rd=%02h ovf=%b ocf=%b pin=%b oirq=%b cirq=%b",
								results_checked, want.read_data, want.overflow_flag,
								want.compare_flag, want.pwm_pin, want.overflow_irq,
								want.compare_irq, got.read_data, got.overflow_flag,
								got.compare_flag, got.pwm_pin, got.overflow_irq,
								got.compare_irq);
					end
				end
				results_checked++;
				recv_wait = draw_idle();
			end
			if (hold_off || recv_wait != 0) begin
				out_ready <= 1'b0;
				if (!hold_off)
					recv_wait--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// long receiver stall so both pipeline stages fill and in_ready drops
	initial begin
		while (accepted_count < 400)
			@(posedge clk);
		hold_off <= 1'b1;
		repeat (80) @(posedge clk);
		hold_off <= 1'b0;
	end

	// overall time limit
	initial begin
		#400000;
		$display("tb: failure");
		$finish;
	end

	// stimulus, reset and end of run
	initial begin
		int seg_ticks;
		int roll;
		logic [7:0] ctl;

		tm_ctrl = '0;
		tm_count = '0;
		tm_ocr = '0;
		tm_ocr_buf = '0;
		tm_prescale = '0;
		tm_enables = '0;
		tm_flags = '0;
		tm_pin = 1'b0;

		// directed: reset contents, masking, stopped clock codes, wrap and match
		queue_item(OP_READ, SEL_CONTROL, 8'h00);
		queue_item(OP_WRITE, SEL_ENABLE, 8'hFF);
		queue_item(OP_READ, SEL_ENABLE, 8'h00);
		// force-compare bit dropped, clock select 7 stops, fast pwm with com set
		queue_item(OP_WRITE, SEL_CONTROL, 8'hFF);
		queue_item(OP_READ, SEL_CONTROL, 8'h00);
		queue_item(OP_TICK, SEL_CONTROL, 8'h00);
		// fast pwm: compare write only reaches the buffer, read returns the buffer
		queue_item(OP_WRITE, SEL_COMPARE, 8'h00);
		queue_item(OP_READ, SEL_COMPARE, 8'h00);
		// phase-correct bits behave as normal mode, divide by one
		queue_item(OP_WRITE, SEL_CONTROL, 8'h41);
		queue_item(OP_WRITE, SEL_COUNT, COUNT_TOP);
		queue_item(OP_TICK, 3'd7, 8'hFF);
		queue_item(OP_TICK, SEL_COUNT, 8'h00);
		queue_item(OP_READ, SEL_FLAGS, 8'h00);
		// write one to clear, one flag at a time
		queue_item(OP_WRITE, SEL_FLAGS, 8'h01);
		queue_item(OP_WRITE, SEL_FLAGS, 8'hFE);
		// ctc with toggle, clock select 6 stops
		queue_item(OP_WRITE, SEL_CONTROL, 8'h1E);
		queue_item(OP_TICK, SEL_COUNT, 8'h00);
		// unused selects and the unused operation code
		queue_item(OP_WRITE, 3'd5, 8'hAA);
		queue_item(OP_READ, 3'd7, 8'h00);
		queue_item(2'd3, SEL_COUNT, 8'hFF);
		// fast pwm with com set across top, buffer reload at the wrap
		queue_item(OP_WRITE, SEL_CONTROL, 8'h79);
		queue_item(OP_WRITE, SEL_COUNT, 8'hFE);
		queue_item(OP_TICK, SEL_CONTROL, 8'h00);
		queue_item(OP_TICK, SEL_CONTROL, 8'h00);
		queue_item(OP_READ, SEL_COUNT, 8'h00);

		// random: program a mode, then run a burst of ticks with register traffic
		while (total_items < RANDOM_ITEMS) begin
			roll = $urandom_range(0, 99);
			ctl = 8'($urandom_range(0, 255));
			if (roll < 65)
				ctl[2:0] = CS_DIV1;
			else if (roll < 80)
				ctl[2:0] = CS_DIV8;
			else if (roll < 85)
				ctl[2:0] = CS_DIV64;
			queue_item(OP_WRITE, SEL_CONTROL, ctl);
			if ($urandom_range(0, 1) == 1)
				queue_item(OP_WRITE, SEL_COMPARE, pick_byte());
			if ($urandom_range(0, 2) == 0)
				queue_item(OP_WRITE, SEL_ENABLE, 8'($urandom_range(0, 255)));
			// start near the top so wraps are frequent
			if ($urandom_range(0, 2) != 0)
				queue_item(OP_WRITE, SEL_COUNT, COUNT_TOP - 8'($urandom_range(0, 40)));
			seg_ticks = $urandom_range(8, 70);
			repeat (seg_ticks) begin
				roll = $urandom_range(0, 99);
				if (roll < 80)
					queue_item(OP_TICK, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
				else if (roll < 88)
					queue_item(OP_READ, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
				else if (roll < 92)
					queue_item(OP_WRITE, SEL_FLAGS, 8'($urandom_range(0, 255)));
				else if (roll < 95)
					queue_item(OP_WRITE, SEL_COMPARE, pick_byte());
				else if (roll < 97)
					queue_item(OP_WRITE, SEL_COUNT, pick_byte());
				else
					queue_item(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
						8'($urandom_range(0, 255)));
			end
			queue_item(OP_READ, SEL_FLAGS, 8'($urandom_range(0, 255)));
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// drain: everything accepted, every prediction checked, then a short tail
		while (accepted_count < total_items)
			@(posedge clk);
		while (status_words_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("covered %0d bus transactions and %0d checked results", accepted_count,
			results_checked);
		$display("timer wrapped %0d times and hit compare %0d times; %0d mismatches",
			wraps_seen, matches_seen, error_count);
		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
